[src/sts_pkg.sv]
// Shared types, constants and helper functions for the SQL token scanner.
package sts_pkg;

    // Longest token the length counter tracks before it saturates
    localparam int MAX_TOKEN_LENGTH = 255;
    localparam int CNT_W = $clog2(MAX_TOKEN_LENGTH + 1);

    // Keyword window and keyword table geometry
    localparam int WIN_BYTES = 6;
    localparam int WIN_W = 8 * WIN_BYTES;
    localparam int KW_COUNT = 9;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);

    // Special characters
    localparam logic [7:0] CHAR_NUL = 8'h00;
    localparam logic [7:0] CHAR_QUOTE = 8'h27;
    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;

    // Keywords packed right-aligned, first character in the highest used byte
    localparam logic [WIN_W-1:0] KW_TEXT [KW_COUNT] = '{
        48'h53454C454354,  // SELECT
        48'h000046524F4D,  // FROM
        48'h005748455245,  // WHERE
        48'h494E53455254,  // INSERT
        48'h0000494E544F,  // INTO
        48'h56414C554553,  // VALUES
        48'h44454C455445,  // DELETE
        48'h555044415445,  // UPDATE
        48'h000000534554   // SET
    };
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd6, 3'd4, 3'd5, 3'd6, 3'd4, 3'd6, 3'd6, 3'd6, 3'd3
    };

    // Scanner mode, one-hot
    typedef enum logic [3:0] {
        MODE_IDLE = 4'b0001,
        MODE_WORD = 4'b0010,
        MODE_NUM  = 4'b0100,
        MODE_STR  = 4'b1000
    } t_mode;

    // Token kinds as reported on the output
    typedef enum logic [2:0] {
        KIND_KEYWORD = 3'd0,
        KIND_IDENT   = 3'd1,
        KIND_NUMBER  = 3'd2,
        KIND_STRING  = 3'd3,
        KIND_SYMBOL  = 3'd4,
        KIND_END     = 3'd5
    } t_kind;

    // One result request
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  tok_byte;
        logic        present;
        logic        done;
        logic [7:0]  length;
        logic [3:0]  kw_num;
        logic        last;
    } t_result;

    // All result requests caused by one input byte
    typedef struct packed {
        logic [1:0]        n;
        t_result [2:0]     res;
    } t_run;

    // Keyword lookup outcome
    typedef struct packed {
        logic        hit;
        logic [3:0]  idx;
    } t_kw_hit;

    function automatic logic f_is_letter(input logic [7:0] b);
        return (b >= 8'd65 && b <= 8'd90) || (b >= 8'd97 && b <= 8'd122);
    endfunction

    function automatic logic f_is_digit(input logic [7:0] b);
        return b >= 8'd48 && b <= 8'd57;
    endfunction

    function automatic logic f_is_punct(input logic [7:0] b);
        return b >= 8'd33 && b <= 8'd126 && !f_is_letter(b) && !f_is_digit(b);
    endfunction

    function automatic t_kind f_mode_kind(input t_mode m);
        t_kind k;
        case (m)
            MODE_NUM: k = KIND_NUMBER;
            MODE_STR: k = KIND_STRING;
            default:  k = KIND_IDENT;
        endcase
        return k;
    endfunction

    // Compare window and count against every keyword in parallel
    function automatic t_kw_hit f_keyword(input logic [CNT_W-1:0] cnt,
                                          input logic [WIN_W-1:0] win);
        t_kw_hit h;
        h = '0;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            if (cnt == CNT_W'(KW_LEN[k]) && win == KW_TEXT[k]) begin
                h.hit = 1'b1;
                h.idx = 4'(k);
            end
        end
        return h;
    endfunction

    // Reported length saturates at the 8-bit field maximum
    function automatic logic [7:0] f_sat_len(input logic [CNT_W-1:0] cnt);
        logic [31:0] wide;
        wide = 32'(cnt);
        return (wide > 32'd255) ? 8'hFF : wide[7:0];
    endfunction

    // Build the request that closes a token
    function automatic t_result f_close(input t_mode m,
                                        input logic [CNT_W-1:0] cnt,
                                        input logic [WIN_W-1:0] win,
                                        input logic [7:0] b,
                                        input logic present);
        t_result r;
        t_kw_hit h;
        h = f_keyword(cnt, win);
        r = '0;
        r.kind = f_mode_kind(m);
        r.tok_byte = present ? b : 8'd0;
        r.present = present;
        r.done = 1'b1;
        r.length = f_sat_len(cnt);
        if (m == MODE_WORD && h.hit) begin
            r.kind = KIND_KEYWORD;
            r.kw_num = h.idx;
        end
        return r;
    endfunction

    // Build an echo request for a byte inside an open token
    function automatic t_result f_echo(input t_kind k, input logic [7:0] b);
        t_result r;
        r = '0;
        r.kind = k;
        r.tok_byte = b;
        r.present = 1'b1;
        return r;
    endfunction

endpackage

[src/sts_front.sv]
// Front end: accepts bytes, tracks scanner state and builds result runs.
module sts_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [7:0]    i_text_byte,
    input  logic          i_end_of_text,
    input  logic          i_full,
    output logic          o_push,
    output sts_pkg::t_run o_run
);
    import sts_pkg::*;

    t_mode              r_mode, n_mode;
    logic [WIN_W-1:0]   r_win, n_win;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [CNT_W-1:0]   cnt_inc;
    logic [WIN_W-1:0]   win_shift;
    t_result [2:0]      res;
    t_result            cls;
    logic [1:0]         cnt;
    logic               eot;
    logic               cont;
    logic               accept;
    logic [7:0]         b;

    assign b = i_text_byte;
    assign accept = i_valid && !i_full;
    assign o_stall = i_full;

    // Saturating count and window shift for a byte that extends the token
    assign cnt_inc = (r_cnt < CNT_W'(MAX_TOKEN_LENGTH)) ? r_cnt + CNT_W'(1) : r_cnt;
    assign win_shift = (r_mode == MODE_WORD && r_cnt < CNT_W'(WIN_BYTES)) ?
                       {r_win[WIN_W-9:0], b} : r_win;
    assign cont = (r_mode == MODE_WORD &&
                   (f_is_letter(b) || f_is_digit(b) || b == CHAR_UNDERSCORE)) ||
                  (r_mode == MODE_NUM && f_is_digit(b)) ||
                  (r_mode == MODE_STR);

    // Classify the byte and collect the requests it causes
    always_comb begin
        n_mode = r_mode;
        n_win = r_win;
        n_cnt = r_cnt;
        res = '0;
        cnt = 2'd0;
        eot = i_end_of_text;
        cls = f_close(r_mode, r_cnt, r_win, CHAR_NUL, 1'b0);
        if (b == CHAR_NUL) begin
            if (r_mode != MODE_IDLE) begin
                res[0] = cls;
                cnt = 2'd1;
            end
            eot = 1'b1;
        end else if (r_mode == MODE_STR && b == CHAR_QUOTE) begin
            res[0] = cls;
            cnt = 2'd1;
            n_mode = MODE_IDLE;
            n_win = '0;
            n_cnt = '0;
        end else if (cont) begin
            n_cnt = cnt_inc;
            n_win = win_shift;
            if (eot) begin
                res[0] = f_close(r_mode, cnt_inc, win_shift, b, 1'b1);
            end else begin
                res[0] = f_echo(f_mode_kind(r_mode), b);
            end
            cnt = 2'd1;
        end else begin
            // Close the broken token, then scan the byte from idle
            if (r_mode != MODE_IDLE) begin
                res[0] = cls;
                cnt = 2'd1;
            end
            n_mode = MODE_IDLE;
            n_win = '0;
            n_cnt = '0;
            if (f_is_letter(b) || f_is_digit(b)) begin
                n_mode = f_is_letter(b) ? MODE_WORD : MODE_NUM;
                n_win = {{(WIN_W-8){1'b0}}, b};
                n_cnt = CNT_W'(1);
                if (eot) begin
                    res[cnt] = f_close(n_mode, CNT_W'(1), n_win, b, 1'b1);
                end else begin
                    res[cnt] = f_echo(f_mode_kind(n_mode), b);
                end
                cnt = cnt + 2'd1;
            end else if (b == CHAR_QUOTE) begin
                n_mode = MODE_STR;
                if (eot) begin
                    res[cnt] = f_close(MODE_STR, '0, '0, CHAR_NUL, 1'b0);
                    cnt = cnt + 2'd1;
                end
            end else if (f_is_punct(b)) begin
                res[cnt] = f_echo(KIND_SYMBOL, b);
                res[cnt].done = 1'b1;
                res[cnt].length = 8'd1;
                cnt = cnt + 2'd1;
            end
        end
        // Append the end token and drop back to reset state
        if (eot) begin
            res[cnt] = '0;
            res[cnt].kind = KIND_END;
            res[cnt].done = 1'b1;
            cnt = cnt + 2'd1;
            n_mode = MODE_IDLE;
            n_win = '0;
            n_cnt = '0;
        end
        if (cnt != 2'd0) begin
            res[cnt - 2'd1].last = 1'b1;
        end
    end

    assign o_push = accept && (cnt != 2'd0);
    assign o_run.n = cnt;
    assign o_run.res = res;

    // Advance scanner state on each accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_win <= '0;
            r_cnt <= '0;
        end else if (accept) begin
            r_mode <= n_mode;
            r_win <= n_win;
            r_cnt <= n_cnt;
        end
    end

    a_eot_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_end_of_text || b == CHAR_NUL)) |=> (r_mode == MODE_IDLE && r_cnt == '0))
        else $error("scanner not idle after end of text");

    a_push_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> o_run.res[o_run.n - 2'd1].last)
        else $error("pushed run lacks a final marker");

    a_win_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_IDLE) |-> (r_cnt == '0 && r_win == '0))
        else $error("idle scanner holds token state");

endmodule

[src/sts_queue.sv]
// Short queue of result runs between the front and back ends.
module sts_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sts_pkg::t_run i_run,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output sts_pkg::t_run o_head
);
    import sts_pkg::*;

    t_run               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr, r_rd;
    logic [QPTR_W:0]    r_count;

    assign o_full = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head = r_mem[r_rd];

    // Store pushed runs
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_run;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (QPTR_W+1)'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - (QPTR_W+1)'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("pop from empty queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QPTR_W+1)'(QUEUE_DEPTH))
        else $error("queue occupancy out of range");

endmodule

[src/sts_back.sv]
// Back end: walks each queued run and presents its results one per cycle while the output is not stalled.
module sts_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  sts_pkg::t_run    i_head,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output sts_pkg::t_result o_result
);
    import sts_pkg::*;

    logic       r_valid;
    t_result    r_res;
    logic [1:0] r_idx;
    logic       out_free;
    logic       load;
    logic       at_last;

    assign out_free = !r_valid || !i_stall;
    assign load = out_free && !i_empty;
    assign at_last = (r_idx == i_head.n - 2'd1);
    assign o_pop = load && at_last;
    assign o_valid = r_valid;
    assign o_result = r_res;

    // Hold the output request until taken, then step through the run
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx <= '0;
        end else begin
            if (out_free) begin
                r_valid <= !i_empty;
            end
            if (load) begin
                r_idx <= at_last ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res <= i_head.res[r_idx];
        end
    end

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty |-> (r_idx < i_head.n))
        else $error("run index beyond run length");

    a_idx_zero_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_empty |-> (r_idx == 2'd0))
        else $error("partial run left with empty queue");

endmodule

[src/sql_token_scanner_top.sv]
// Top level of the SQL token scanner: front end, run queue and back end.
// Each byte's results are written into the run queue, then loaded into the output register.
// Throughput: one byte per cycle while each byte yields at most one result and the
// output is not stalled; the single output register shows a byte's results in turn,
// and the four-run queue absorbs the difference until it fills and stalls the input.
// Reset (synchronous, active low) clears scanner state, the queue and output valid.
module sql_token_scanner_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_text_byte,
    input  logic       i_end_of_text,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_token_kind,
    output logic [7:0] o_token_byte,
    output logic       o_byte_present,
    output logic       o_token_done,
    output logic [7:0] o_token_length,
    output logic [3:0] o_keyword_number,
    output logic       o_last_of_run
);
    import sts_pkg::*;

    logic    push, full, pop, empty;
    t_run    run_in, run_head;
    t_result res;

    sts_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .i_full        (full),
        .o_push        (push),
        .o_run         (run_in)
    );

    sts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_run   (run_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_head  (run_head)
    );

    sts_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (empty),
        .i_head   (run_head),
        .o_pop    (pop),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (res)
    );

    // Unpack the result request onto the output fields
    assign o_token_kind = res.kind;
    assign o_token_byte = res.tok_byte;
    assign o_byte_present = res.present;
    assign o_token_done = res.done;
    assign o_token_length = res.length;
    assign o_keyword_number = res.kw_num;
    assign o_last_of_run = res.last;

endmodule
